@@ hw/rtl/spq_pkg.sv @@
// spq_pkg: command, status and cell operation codes for the sorted priority queue
// no dependencies; imported by spq_cell and sorted_priority_queue
package spq_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DELETE  = 2'd1,
    CMD_DISPLAY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_EMPTY    = 2'd2
  } status_t;

  // what every cell of the chain does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_ROTATE = 2'd2
  } cell_op_t;

  // per-cell control from the queue controller
  typedef struct packed {
    cell_op_t op;
    logic     occupied;  // cell index below the count
    logic     tail;      // cell holds the smallest stored entry
  } cell_ctl_t;

endpackage

@@ hw/rtl/spq_cell.sv @@
// spq_cell: one slot of the sorted chain, holds one value
// depends on spq_pkg; instantiated in a row by sorted_priority_queue
module spq_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  spq_pkg::cell_ctl_t            ctl,
  input  logic signed [VALUE_WIDTH-1:0] new_value,
  input  logic                          left_take,   // left neighbor takes the new value or shifts
  input  logic signed [VALUE_WIDTH-1:0] left_value,
  input  logic signed [VALUE_WIDTH-1:0] right_value,
  input  logic signed [VALUE_WIDTH-1:0] head_value,
  output logic                          take,
  output logic signed [VALUE_WIDTH-1:0] value
);
  import spq_pkg::*;

  logic signed [VALUE_WIDTH-1:0] value_r;
  logic signed [VALUE_WIDTH-1:0] value_nxt;

  // new value goes at or ahead of this slot: slot is free or new value >= stored
  assign take  = !ctl.occupied || (new_value >= value_r);
  assign value = value_r;

  always_comb begin
    value_nxt = value_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (left_take) begin
          value_nxt = left_value;
        end else if (take) begin
          value_nxt = new_value;
        end
      end
      CELL_ROTATE: begin
        // display rotates the occupied part toward the head, head wraps to the tail
        if (ctl.occupied) begin
          value_nxt = ctl.tail ? head_value : right_value;
        end
      end
      default: value_nxt = value_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
// sorted_priority_queue: bounded priority queue kept sorted largest first
// usage:
//   in_valid/in_stall carries one command item (in_cmd, in_value); an item is
//   taken at a rising edge with in_valid high and in_stall low.
//   out_valid/out_stall carries result items held in an output register.
//   insert and delete give one result on the cycle after acceptance: insert
//   compares the new value in every cell of the chain at once and shifts the
//   smaller entries one slot down in that same cycle; delete drops the tail.
//   display gives one result per stored entry, largest first, one per cycle
//   while the receiver takes them; the chain rotates toward the head and the
//   head cell feeds the output, so after count rotations the order is back.
//   in_stall is high during a display and whenever a result is waiting that
//   the receiver stalls; a stalled result holds its value.
//   reset (synchronous, rst_n low) empties the queue and drops any pending
//   result; stored values are not cleared and are never read before written.
// depends on spq_pkg and spq_cell
module sorted_priority_queue #(
  parameter int DEPTH       = 8,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_cmd,
  input  logic signed [VALUE_WIDTH-1:0]       in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_status,
  output logic signed [VALUE_WIDTH-1:0]       out_entry_value,
  output logic [$clog2(DEPTH)-1:0]            out_position,
  output logic [$clog2(DEPTH+1)-1:0]          out_occupancy,
  output logic                                out_last
);
  import spq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic {
    S_IDLE,
    S_DISP
  } state_t;

  state_t                        state_r, state_nxt;
  logic [IW-1:0]                 idx_r, idx_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic                          out_valid_r, out_valid_nxt;
  status_t                       out_status_r, out_status_nxt;
  logic signed [VALUE_WIDTH-1:0] out_entry_r, out_entry_nxt;
  logic [IW-1:0]                 out_pos_r, out_pos_nxt;
  logic [CW-1:0]                 out_occ_r, out_occ_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          load_ok;
  logic                          accept_in;
  cmd_t                          cmd;
  logic                          full;
  logic                          empty;
  logic                          emit_disp;
  logic [IW-1:0]                 disp_pos;
  logic                          disp_last;
  cell_op_t                      op;

  cell_ctl_t                     ctl     [DEPTH];
  logic                          take    [DEPTH];
  logic signed [VALUE_WIDTH-1:0] cell_val[DEPTH];

  assign cmd       = cmd_t'(in_cmd);
  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign load_ok   = !out_valid_r || !out_stall;
  assign in_stall  = (state_r == S_DISP) || !load_ok;
  assign accept_in = in_valid && !in_stall;

  // first display result leaves in the accept cycle, the rest from S_DISP
  assign emit_disp = (accept_in && (cmd == CMD_DISPLAY) && !empty) ||
                     ((state_r == S_DISP) && load_ok);
  assign disp_pos  = (state_r == S_DISP) ? idx_r : '0;
  assign disp_last = ((CW'(disp_pos) + CW'(1)) == count_r);

  assign op = (accept_in && (cmd == CMD_INSERT) && !full) ? CELL_INSERT :
              emit_disp ? CELL_ROTATE : CELL_HOLD;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                          lt;
    logic signed [VALUE_WIDTH-1:0] lv;
    logic signed [VALUE_WIDTH-1:0] rv;

    assign ctl[i].op       = op;
    assign ctl[i].occupied = (CW'(i) < count_r);
    assign ctl[i].tail     = (CW'(i + 1) == count_r);

    if (i == 0) begin : g_head
      assign lt = 1'b0;
      assign lv = cell_val[0];
    end else begin : g_body
      assign lt = take[i-1];
      assign lv = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_end
      assign rv = cell_val[0];
    end else begin : g_mid
      assign rv = cell_val[i+1];
    end

    spq_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl[i]),
      .new_value  (in_value),
      .left_take  (lt),
      .left_value (lv),
      .right_value(rv),
      .head_value (cell_val[0]),
      .take       (take[i]),
      .value      (cell_val[i])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_entry_nxt  = out_entry_r;
    out_pos_nxt    = out_pos_r;
    out_occ_nxt    = out_occ_r;
    out_last_nxt   = out_last_r;

    if (emit_disp) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = STAT_OK;
      out_entry_nxt  = cell_val[0];
      out_pos_nxt    = disp_pos;
      out_occ_nxt    = count_r;
      out_last_nxt   = disp_last;
      idx_nxt        = IW'(CW'(disp_pos) + CW'(1));
      state_nxt      = disp_last ? S_IDLE : S_DISP;
    end else if (accept_in) begin
      out_valid_nxt  = 1'b1;
      out_entry_nxt  = '0;
      out_pos_nxt    = '0;
      out_last_nxt   = 1'b1;
      out_status_nxt = STAT_OK;
      out_occ_nxt    = count_r;
      case (cmd)
        CMD_INSERT: begin
          if (full) begin
            out_status_nxt = STAT_OVERFLOW;
          end else begin
            count_nxt   = count_r + CW'(1);
            out_occ_nxt = count_r + CW'(1);
          end
        end
        CMD_DELETE: begin
          if (empty) begin
            out_status_nxt = STAT_EMPTY;
          end else begin
            count_nxt   = count_r - CW'(1);
            out_occ_nxt = count_r - CW'(1);
          end
        end
        CMD_DISPLAY: out_status_nxt = STAT_EMPTY;  // only reached when empty
        default:     out_status_nxt = STAT_OK;
      endcase
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_status_r <= out_status_nxt;
    out_entry_r  <= out_entry_nxt;
    out_pos_r    <= out_pos_nxt;
    out_occ_r    <= out_occ_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_value = out_entry_r;
  assign out_position    = out_pos_r;
  assign out_occupancy   = out_occ_r;
  assign out_last        = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept_in && (cmd == CMD_INSERT) && !full) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not grow the queue");

  a_disp_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DISP) |-> (!empty && (CW'(idx_r) < count_r)))
    else $error("display index outside stored entries");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) && (count_r >= CW'(2))) |-> (cell_val[0] >= cell_val[1]))
    else $error("head entries out of order");

endmodule
